### sv/dlsgd_pkg.sv
// shared types, constants and helpers for the dense layer sgd weight update core
package dlsgd_pkg;

  localparam int MAX_OUT = 64;
  localparam int MAX_IN = 64;
  localparam int ROW_WORDS = MAX_IN + 1;
  localparam int W_DEPTH = MAX_OUT * ROW_WORDS;
  localparam int W_AW = $clog2(W_DEPTH);
  localparam int X_AW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int RW = $clog2(MAX_OUT);
  localparam int CW = $clog2(MAX_IN + 1);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_GRAD = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [1:0] REG_OUT_COUNT = 2'd0;
  localparam logic [1:0] REG_IN_COUNT = 2'd1;
  localparam logic [1:0] REG_LEARN_RATE = 2'd2;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row;
    logic [6:0] col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic status;
  } out_word_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [1:0] cmd;
    logic err;
    logic [W_AW-1:0] base;
    logic [6:0] col;
    logic [CW-1:0] nin;
    logic signed [31:0] value;
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) r = 32'sh7fff_ffff;
    else if (x < SAT_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

### sv/dense_layer_sgd_weight_update_core.sv
// top level of the dense layer sgd weight update core
// A gradient word walks its row one weight at a time through the weight memory:
// read (S_RD), multiply (S_MUL1, S_MUL2) and write-back (S_WR) per weight, the
// bias word last. Input words queue in a two-entry job queue while the row engine
// is busy, and one result word waits in the output register.
module dense_layer_sgd_weight_update_core (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_push,
  output logic in_full,
  input  dlsgd_pkg::in_word_t in_word,
  output logic out_empty,
  input  logic out_pop,
  output dlsgd_pkg::out_word_t out_word
);
  import dlsgd_pkg::*;

  logic [15:0] rate;
  logic job_valid, job_take;
  job_t job;

  dlsgd_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .rate(rate), .job_valid(job_valid), .job(job), .job_take(job_take)
  );
  dlsgd_back u_back (
    .clk(clk), .rst_n(rst_n), .rate(rate), .job_valid(job_valid), .job(job),
    .job_take(job_take), .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word)
  );
endmodule

### sv/dlsgd_ram.sv
// generic single port write, single port registered read ram
module dlsgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/dlsgd_front.sv
// front end: config registers, range checks and job queue
module dlsgd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_push,
  output logic             in_full,
  input  dlsgd_pkg::in_word_t in_word,
  output logic [15:0]      rate,
  output logic             job_valid,
  output dlsgd_pkg::job_t  job,
  input  logic             job_take
);
  import dlsgd_pkg::*;

  logic [6:0] out_count_r, in_count_r;
  logic [15:0] rate_r;
  job_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [CW-1:0] nout, nin;
  logic err;
  job_t nj;
  logic push_ok;

  assign rate = rate_r;
  assign in_full = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rp_r];
  assign push_ok = in_push && !in_full;

  always_comb begin
    nout = (out_count_r > 7'(MAX_OUT)) ? CW'(MAX_OUT) : CW'(out_count_r);
    nin = (in_count_r > 7'(MAX_IN)) ? CW'(MAX_IN) : CW'(in_count_r);
    unique case (in_word.cmd)
      CMD_LOAD: err = ({1'b0, in_word.col} >= 8'(nin));
      CMD_GRAD: err = ({1'b0, in_word.row} >= 7'(nout));
      default:  err = ({1'b0, in_word.row} >= 7'(nout)) ||
                      ({1'b0, in_word.col} > 8'(nin));
    endcase
    nj.cmd = in_word.cmd;
    nj.err = err;
    nj.base = W_AW'(in_word.row[RW-1:0]) * W_AW'(ROW_WORDS);
    nj.col = in_word.col;
    nj.nin = nin;
    nj.value = in_word.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_count_r <= 7'd64;
      in_count_r <= 7'd64;
      rate_r <= 16'd655;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OUT_COUNT:  out_count_r <= cfg_data[6:0];
          REG_IN_COUNT:   in_count_r <= cfg_data[6:0];
          REG_LEARN_RATE: rate_r <= cfg_data;
          default: ;
        endcase
      end
      if (push_ok) wp_r <= ~wp_r;
      if (job_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(job_take);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= nj;
  end
endmodule

### sv/dlsgd_back.sv
// back end: weight and input memories, row update sequencer, result register
module dlsgd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      rate,
  input  logic             job_valid,
  input  dlsgd_pkg::job_t  job,
  output logic             job_take,
  output logic             out_empty,
  input  logic             out_pop,
  output dlsgd_pkg::out_word_t out_word
);
  import dlsgd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_WR = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] st_r, st_nxt;
  job_t j_r;
  logic [CW-1:0] c_r;
  logic signed [63:0] p_r;
  logic signed [63:0] d_r;
  logic signed [31:0] rdv_r;
  logic ov_r;
  out_word_t res_r;
  logic w_we, x_we;
  logic [W_AW-1:0] w_waddr, w_raddr;
  logic [31:0] w_wdata, w_rdata, x_rdata;
  logic [X_AW-1:0] x_addr;
  logic is_bias;
  logic signed [63:0] gx, rp, diff;

  dlsgd_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_w (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );
  dlsgd_ram #(.WIDTH(32), .DEPTH(MAX_IN)) u_x (
    .clk(clk), .we(x_we), .waddr(x_addr), .wdata(j_r.value),
    .raddr(x_addr), .rdata(x_rdata)
  );

  assign out_empty = !ov_r;
  assign out_word = res_r;
  assign job_take = (st_r == S_IDLE) && job_valid;
  assign is_bias = (c_r == j_r.nin);
  assign x_addr = (j_r.cmd == CMD_GRAD) ? X_AW'(c_r) : X_AW'(j_r.col);
  assign w_raddr = (j_r.cmd == CMD_GRAD) ? j_r.base + W_AW'(c_r)
                                         : j_r.base + W_AW'(j_r.col);
  assign x_we = (st_r == S_RD) && (j_r.cmd == CMD_LOAD) && !j_r.err;
  assign gx = 64'(j_r.value) * 64'($signed(x_rdata));
  assign rp = $signed({1'b0, rate}) * p_r;
  assign diff = 64'($signed(w_rdata)) - d_r;

  always_comb begin
    w_we = 1'b0;
    w_waddr = w_raddr;
    w_wdata = j_r.value;
    if (st_r == S_RD && j_r.cmd == CMD_WRITE && !j_r.err) w_we = 1'b1;
    if (st_r == S_WR) begin
      w_we = 1'b1;
      w_wdata = sat32(diff);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (job_valid) st_nxt = S_RD;
      S_RD: begin
        if (j_r.err || j_r.cmd == CMD_WRITE || j_r.cmd == CMD_LOAD) st_nxt = S_DONE;
        else if (j_r.cmd == CMD_READ) st_nxt = S_READ;
        else st_nxt = S_MUL1;
      end
      S_MUL1: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_WR;
      S_WR: st_nxt = is_bias ? S_DONE : S_RD;
      S_READ: st_nxt = S_DONE;
      S_DONE: if (!ov_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && !ov_r) ov_r <= 1'b1;
      else if (out_pop && ov_r) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      j_r <= job;
      c_r <= '0;
      rdv_r <= '0;
    end
    if (st_r == S_MUL1) p_r <= is_bias ? 64'(j_r.value) : (gx >>> 16);
    if (st_r == S_MUL2) d_r <= rp >>> 16;
    if (st_r == S_WR) c_r <= c_r + CW'(1);
    if (st_r == S_READ) rdv_r <= w_rdata;
    if (st_r == S_DONE && !ov_r) begin
      res_r.read_value <= rdv_r;
      res_r.status <= j_r.err;
    end
  end
endmodule
